// ----- hw/rtl/srpd_pkg.sv -----
// ----------------------------------------------------------------------------
// srpd_pkg: shared types and constants of the snapshot page decoder
// Result record, per-page decoder state, marker bytes and register indexes.
// ----------------------------------------------------------------------------
package srpd_pkg;

  // most results one input item can cause (one decision plus a four-byte flush)
  localparam int MAX_RES = 5;

  localparam logic [7:0] MARK_ED   = 8'hED;
  localparam logic [7:0] MARK_ZERO = 8'h00;

  // configuration register indexes
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] count;
    logic       last;
    logic       done;
  } res_t;

  typedef struct packed {
    logic [3:0][7:0] win;      // entry 0 is the oldest byte
    logic [2:0]      fill;
    logic [1:0]      skip;
    logic [15:0]     prod;
    logic            stopped;
  } state_t;

endpackage

// ----- hw/rtl/srpd_decode.sv -----
// ----------------------------------------------------------------------------
// srpd_decode: one-item decode step
// From the page state and one byte, gives the next state and up to five runs.
// ----------------------------------------------------------------------------
module srpd_decode (
  input  logic                                  mode_i,
  input  logic [15:0]                           limit_i,
  input  srpd_pkg::state_t                      st_i,
  input  logic [7:0]                            byte_i,
  input  logic                                  end_i,
  output srpd_pkg::state_t                      st_o,
  output srpd_pkg::res_t [srpd_pkg::MAX_RES-1:0] res_o,
  output logic [2:0]                            n_o
);
  import srpd_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [7:0]  cnt;
    logic [15:0] prod;
    logic        stopped;
  } emit_t;

  // apply the output limit to one run
  function automatic emit_t emit_run(logic [15:0] prod, logic stp, logic [15:0] lim,
                                     logic [7:0] cnt);
    emit_t       e;
    logic [16:0] sum;
    logic [15:0] avail;
    e.ok      = 1'b0;
    e.cnt     = cnt;
    e.prod    = prod;
    e.stopped = stp;
    avail     = lim - prod;
    sum       = '0;
    if (!stp && cnt != 8'd0) begin
      if (lim != 16'd0 && prod >= lim) begin
        e.stopped = 1'b1;
      end else begin
        if (lim != 16'd0 && {8'd0, cnt} >= avail) begin
          e.cnt     = avail[7:0];
          e.stopped = 1'b1;
        end
        sum    = {1'b0, prod} + {9'd0, e.cnt};
        e.prod = sum[16] ? 16'hFFFF : sum[15:0];
        e.ok   = 1'b1;
      end
    end
    return e;
  endfunction

  state_t     st;
  emit_t      e;
  logic [7:0] val;
  logic [7:0] cnt;
  logic [2:0] n;
  logic [15:0] room;
  logic [2:0]  lit;
  res_t [MAX_RES-1:0] res;

  always_comb begin
    st   = st_i;
    n    = 3'd0;
    res  = '0;
    val  = 8'd0;
    cnt  = 8'd0;
    e    = '0;
    room = 16'd0;
    lit  = 3'd0;

    if (!st.stopped) begin
      if (st.fill[2]) begin
        // window full: decide the oldest byte, then shift the new one in
        if (st.skip != 2'd0) begin
          st.skip = st.skip - 2'd1;
        end else if (st.win[0] == MARK_ZERO && st.win[1] == MARK_ED &&
                     st.win[2] == MARK_ED && st.win[3] == MARK_ZERO) begin
          st.stopped = 1'b1;
        end else begin
          if (mode_i && st.win[0] == MARK_ED && st.win[1] == MARK_ED) begin
            val     = st.win[3];
            cnt     = st.win[2];
            st.skip = 2'd3;
          end else begin
            val = st.win[0];
            cnt = 8'd1;
          end
          e          = emit_run(st.prod, st.stopped, limit_i, cnt);
          st.prod    = e.prod;
          st.stopped = e.stopped;
          if (e.ok) begin
            res[0].value = val;
            res[0].count = e.cnt;
            n            = 3'd1;
          end
        end
        st.win = {byte_i, st.win[3:1]};
      end else begin
        st.win[st.fill[1:0]] = byte_i;
        st.fill              = st.fill + 3'd1;
      end
    end

    if (end_i) begin
      // flush: window bytes past the ones owed to a run are literals,
      // as many as the room left below the limit allows
      room = (st.prod >= limit_i) ? 16'd0 : limit_i - st.prod;
      for (int k = 0; k < 4; k++) begin
        lit = 3'(k) - {1'b0, st.skip};
        if (!st.stopped && 3'(k) < st.fill && 3'(k) >= {1'b0, st.skip} &&
            (limit_i == 16'd0 || {13'd0, lit} < room)) begin
          res[n].value = st.win[k];
          res[n].count = 8'd1;
          n            = n + 3'd1;
        end
      end
      // empty page-done marker
      if (n == 3'd0) begin
        res[0].value = 8'd0;
        res[0].count = 8'd0;
        n            = 3'd1;
      end
      res[n - 3'd1].done = 1'b1;
      st = '0;
    end

    if (n != 3'd0) begin
      res[n - 3'd1].last = 1'b1;
    end
  end

  assign st_o  = st;
  assign res_o = res;
  assign n_o   = n;

endmodule

// ----- hw/rtl/snapshot_rle_page_decoder.sv -----
// ----------------------------------------------------------------------------
// snapshot_rle_page_decoder: streaming run-length page decoder
// Decodes a memory page's compressed bytes into (value, count) runs.
// ----------------------------------------------------------------------------
// path: an accepted item is held in the input register, then decoded into the result buffer
// throughput: one item per cycle while each item gives at most one result and the
//   output does not stall; an item with k results (k <= 5, the most on a page end
//   flush) holds the result buffer until all k have left, and the input stalls meanwhile
// reset: synchronous active-low; clears the page state, empties the buffers,
//   compressed_mode back to 1 and output_limit back to 0
module snapshot_rle_page_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_in,
  input  logic        in_page_end,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_run_value,
  output logic [7:0]  out_run_count,
  output logic        out_last_of_item,
  output logic        out_page_done,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import srpd_pkg::*;

  // configuration registers
  logic        mode_r;
  logic [15:0] limit_r;

  // input register
  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_end_r;

  // page state: look-ahead window, fill, run skip, produced count, stop flag
  state_t      st_r;
  state_t      st_nxt;

  // result buffer, entry 0 is the one on the output port
  res_t [MAX_RES-1:0] res_r;
  res_t [MAX_RES-1:0] res_nxt;
  res_t [MAX_RES-1:0] dec_res;
  logic [2:0]  cnt_r;
  logic [2:0]  dec_n;

  logic        take;
  logic        buf_free;
  logic        load;
  logic        accept;

  // ---------------------------------------------------------------------------
  // handshake
  // ---------------------------------------------------------------------------
  // the buffer takes the next item's results once its last entry leaves
  assign take     = (cnt_r != 3'd0) && !out_stall;
  assign buf_free = (cnt_r == 3'd0) || (cnt_r == 3'd1 && take);
  assign load     = in_v_r && buf_free;
  assign in_stall = in_v_r && !load;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      limit_r <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  mode_r  <= cfg_wdata[0];
        REG_LIMIT: limit_r <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // input register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (accept) begin
      in_v_r <= 1'b1;
    end else if (load) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_byte_in;
      in_end_r  <= in_page_end;
    end
  end

  // ---------------------------------------------------------------------------
  // decode step: window decision, run expansion, limit, page-end flush
  // ---------------------------------------------------------------------------
  srpd_decode u_decode (
    .mode_i  (mode_r),
    .limit_i (limit_r),
    .st_i    (st_r),
    .byte_i  (in_byte_r),
    .end_i   (in_end_r),
    .st_o    (st_nxt),
    .res_o   (dec_res),
    .n_o     (dec_n)
  );

  // page state only moves when an item is decoded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (load) begin
      st_r <= st_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result buffer: loaded whole, drained one entry per cycle unless stalled, by shifting
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < MAX_RES - 1; i++) begin
      res_nxt[i] = res_r[i + 1];
    end
    res_nxt[MAX_RES-1] = res_r[MAX_RES-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (load) begin
      cnt_r <= dec_n;
    end else if (take) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= dec_res;
    end else if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = (cnt_r != 3'd0);
  assign out_run_value    = res_r[0].value;
  assign out_run_count    = res_r[0].count;
  assign out_last_of_item = res_r[0].last;
  assign out_page_done    = res_r[0].done;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(MAX_RES))
    else $error("result buffer count out of range");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_page_done |-> out_last_of_item)
    else $error("page done without last of item");

  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_count == 8'd0 |-> out_page_done && out_run_value == 8'd0)
    else $error("zero-count result that is not the page-done marker");

  a_page_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_end_r |=> st_r.fill == 3'd0 && !st_r.stopped && st_r.prod == 16'd0)
    else $error("page state not cleared after page end");

endmodule
